// ===== hw/rtl/kdlt_pkg.sv =====
// Shared constants, types and sequencer states for the key digraph latency table.
// Used by kdlt_mean_unit and key_digraph_latency_table_top; depends on nothing.
`default_nettype none

package kdlt_pkg;

   localparam int KEY_CODES   = 256;
   localparam int KEY_BITS    = 8;
   localparam int COUNT_BITS  = 16;
   localparam int MEAN_BITS   = 32;
   localparam int FRAC_BITS   = 8;
   localparam int LIMIT_BITS  = 24;
   localparam int TIME_BITS   = 48;
   localparam int ADDR_BITS   = 2 * KEY_BITS;
   localparam int ENTRY_BITS  = COUNT_BITS + MEAN_BITS;
   localparam int ACC_BITS    = MEAN_BITS + COUNT_BITS;
   localparam int STEP_BITS   = $clog2(MEAN_BITS);
   localparam int LIMIT_RESET = 500000;

   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 104;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_WRITE,
      ST_DONE
   } kdlt_state_type;

   typedef struct packed {
      logic                  start;
      logic [MEAN_BITS-1:0]  mean;
      logic [COUNT_BITS-1:0] count;
      logic [LIMIT_BITS-1:0] interval;
   } kdlt_mean_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } kdlt_mean_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/key_digraph_latency_table_top.sv =====
// Top level of the key digraph latency table: sequencer, pair table memory, output register.
// Depends on kdlt_pkg and instantiates kdlt_mean_unit.
`default_nettype none

// Each request beat is one key press (key code, microsecond time stamp). The block
// forms the interval since the previous press modulo 2^48 and, when it is below
// the limit in the csr register, updates the running mean and saturating count of
// the (current, previous) key pair in a 65536-entry table, returning one response
// beat per press. A press whose pair is recorded goes through one table read,
// one multiply, one add and a 32-step restoring divide in the mean unit, then
// one table write, before its response is offered; a press whose pair is not
// recorded skips the divide and the write. req_tready stays low meanwhile. A
// response waiting in the output register does not hold up the next press until
// that press is finished. After reset the table is swept to zero one entry a cycle,
// all 65536 entries, during which no press is accepted; csr writes are taken at any time.

module key_digraph_latency_table_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // csr: interval_limit_us
   input  wire logic                                csr_we,
   input  wire logic [kdlt_pkg::LIMIT_BITS-1:0]     csr_wdata,
   // req_tdata, lowest bit up: key_code[7:0], press_time_us[55:8]
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [kdlt_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // rsp_tdata, lowest bit up: prior_key_code[7:0], interval_us[55:8],
   // pair_count_out[71:56], pair_mean_out[103:72]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [kdlt_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // rsp_tuser, lowest bit up: pair_recorded[0]
   output logic                                     rsp_tuser
);

   kdlt_pkg::kdlt_state_type              state_ff, state_in;

   // Control state
   logic [kdlt_pkg::ADDR_BITS-1:0]        clr_addr_ff, clr_addr_in;
   logic [kdlt_pkg::KEY_BITS-1:0]         last_key_ff;
   logic [kdlt_pkg::TIME_BITS-1:0]        last_time_ff;
   logic [kdlt_pkg::LIMIT_BITS-1:0]       limit_ff;
   logic                                  rsp_valid_ff, rsp_valid_in;

   // Payload of the press at work
   logic [kdlt_pkg::KEY_BITS-1:0]         cur_ff;
   logic [kdlt_pkg::KEY_BITS-1:0]         prev_ff;
   logic [kdlt_pkg::TIME_BITS-1:0]        dt_ff;
   logic [kdlt_pkg::ADDR_BITS-1:0]        addr_ff;
   logic [kdlt_pkg::ENTRY_BITS-1:0]       rd_data_ff;
   logic [kdlt_pkg::COUNT_BITS-1:0]       n_new_ff;
   logic [kdlt_pkg::COUNT_BITS-1:0]       res_count_ff;
   logic [kdlt_pkg::MEAN_BITS-1:0]        res_mean_ff;
   logic                                  res_rec_ff;
   logic [kdlt_pkg::RSP_DATA_BITS-1:0]    rsp_data_ff;
   logic                                  rsp_user_ff;

   // Pair table: count in the upper bits, mean in the lower bits
   logic [kdlt_pkg::ENTRY_BITS-1:0]       pair_mem [2**kdlt_pkg::ADDR_BITS];

   logic                                  req_accept;
   logic                                  load_rsp;
   logic                                  clear_last;
   logic                                  in_range;
   logic                                  record_c;
   logic [kdlt_pkg::COUNT_BITS-1:0]       entry_count;
   logic [kdlt_pkg::MEAN_BITS-1:0]        entry_mean;
   logic [kdlt_pkg::COUNT_BITS-1:0]       n_new_c;
   logic                                  mem_we;
   logic [kdlt_pkg::ADDR_BITS-1:0]        mem_waddr;
   logic [kdlt_pkg::ENTRY_BITS-1:0]       mem_wdata;
   logic                                  mean_start;

   kdlt_pkg::kdlt_mean_cmd_type           mean_cmd;
   kdlt_pkg::kdlt_mean_stat_type          mean_stat;
   logic [kdlt_pkg::MEAN_BITS-1:0]        mean_quotient;

   assign req_accept  = req_tvalid & req_tready;
   assign clear_last  = (clr_addr_ff == {kdlt_pkg::ADDR_BITS{1'b1}});
   assign entry_count = rd_data_ff[kdlt_pkg::ENTRY_BITS-1:kdlt_pkg::MEAN_BITS];
   assign entry_mean  = rd_data_ff[kdlt_pkg::MEAN_BITS-1:0];
   assign in_range    = (int'(cur_ff) < kdlt_pkg::KEY_CODES)
                      && (int'(prev_ff) < kdlt_pkg::KEY_CODES);
   assign record_c    = in_range
                      && (dt_ff < kdlt_pkg::TIME_BITS'(limit_ff));
   // Saturate the count; at the top the update turns into an exponential average
   assign n_new_c     = (entry_count == {kdlt_pkg::COUNT_BITS{1'b1}})
                      ? entry_count : entry_count + kdlt_pkg::COUNT_BITS'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kdlt_pkg::ST_CLEAR:  if (clear_last) state_in = kdlt_pkg::ST_IDLE;
         kdlt_pkg::ST_IDLE:   if (req_accept) state_in = kdlt_pkg::ST_READ;
         kdlt_pkg::ST_READ:   state_in = kdlt_pkg::ST_LOOKUP;
         kdlt_pkg::ST_LOOKUP: state_in = record_c ? kdlt_pkg::ST_DIVIDE : kdlt_pkg::ST_DONE;
         kdlt_pkg::ST_DIVIDE: if (mean_stat.done) state_in = kdlt_pkg::ST_WRITE;
         kdlt_pkg::ST_WRITE:  state_in = kdlt_pkg::ST_DONE;
         kdlt_pkg::ST_DONE:   if (load_rsp) state_in = kdlt_pkg::ST_IDLE;
         default:             state_in = kdlt_pkg::ST_CLEAR;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      load_rsp    = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = addr_ff;
      mem_wdata   = {n_new_ff, mean_quotient};
      mean_start  = 1'b0;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         kdlt_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + kdlt_pkg::ADDR_BITS'(1);
         end
         kdlt_pkg::ST_IDLE:   req_tready = 1'b1;
         kdlt_pkg::ST_LOOKUP: mean_start = record_c;
         kdlt_pkg::ST_WRITE:  mem_we = 1'b1;
         kdlt_pkg::ST_DONE:   load_rsp = ~rsp_valid_ff | rsp_tready;
         default: ;
      endcase
   end

   assign mean_cmd = '{start:    mean_start,
                       mean:     entry_mean,
                       count:    n_new_c,
                       interval: dt_ff[kdlt_pkg::LIMIT_BITS-1:0]};

   kdlt_mean_unit u_mean (
      .clock    (clock),
      .reset    (reset),
      .cmd      (mean_cmd),
      .stat     (mean_stat),
      .quotient (mean_quotient)
   );

   // Hold a finished beat until taken; a new one may load in the same cycle
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kdlt_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         last_key_ff  <= '0;
         last_time_ff <= '0;
         limit_ff     <= kdlt_pkg::LIMIT_BITS'(kdlt_pkg::LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we)
            limit_ff <= csr_wdata;
         if (req_accept) begin
            last_key_ff  <= req_tdata[kdlt_pkg::KEY_BITS-1:0];
            last_time_ff <= req_tdata[kdlt_pkg::KEY_BITS +: kdlt_pkg::TIME_BITS];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cur_ff  <= req_tdata[kdlt_pkg::KEY_BITS-1:0];
         prev_ff <= last_key_ff;
         dt_ff   <= req_tdata[kdlt_pkg::KEY_BITS +: kdlt_pkg::TIME_BITS] - last_time_ff;
         addr_ff <= {req_tdata[kdlt_pkg::KEY_BITS-1:0], last_key_ff};
      end
      if (state_ff == kdlt_pkg::ST_LOOKUP) begin
         n_new_ff     <= n_new_c;
         res_rec_ff   <= record_c;
         res_count_ff <= in_range ? entry_count : '0;
         res_mean_ff  <= in_range ? entry_mean : '0;
      end
      if (state_ff == kdlt_pkg::ST_WRITE) begin
         res_count_ff <= n_new_ff;
         res_mean_ff  <= mean_quotient;
      end
      if (load_rsp) begin
         rsp_data_ff <= {res_mean_ff, 16'(res_count_ff), dt_ff, prev_ff};
         rsp_user_ff <= res_rec_ff;
      end
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we)
         pair_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= pair_mem[addr_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Checks on the sequencer
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kdlt_pkg::ST_CLEAR) |-> !req_tready)
      else $error("press accepted during table clear");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == kdlt_pkg::ST_READ))
      else $error("accepted press did not start a table read");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      mean_stat.done |-> (state_ff == kdlt_pkg::ST_DIVIDE))
      else $error("mean unit finished outside the divide step");

   a_busy_only_divide: assert property (@(posedge clock) disable iff (reset)
      mean_stat.busy |-> (state_ff == kdlt_pkg::ST_DIVIDE))
      else $error("mean unit busy outside the divide step");

   a_recorded_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[71:56] != 16'd0))
      else $error("recorded pair returned with zero count");

endmodule

`default_nettype wire

// ===== hw/rtl/kdlt_mean_unit.sv =====
// Running mean update: one multiply, one add, then a restoring divide, a bit a cycle.
// Depends on kdlt_pkg for widths and the command and status structs.
`default_nettype none

module kdlt_mean_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire kdlt_pkg::kdlt_mean_cmd_type    cmd,
   output kdlt_pkg::kdlt_mean_stat_type        stat,
   output logic [kdlt_pkg::MEAN_BITS-1:0]      quotient
);

   logic                              load_ff, load_in;
   logic                              run_ff, run_in;
   logic                              done_ff, done_in;
   logic [kdlt_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic [kdlt_pkg::ACC_BITS-1:0]     prod_ff, prod_in;
   logic [kdlt_pkg::MEAN_BITS-1:0]    sample_ff, sample_in;
   logic [kdlt_pkg::COUNT_BITS-1:0]   divisor_ff, divisor_in;
   logic [kdlt_pkg::COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [kdlt_pkg::MEAN_BITS-1:0]    quo_ff, quo_in;

   logic [kdlt_pkg::ACC_BITS-1:0]     acc;
   logic [kdlt_pkg::COUNT_BITS:0]     trial;
   logic [kdlt_pkg::COUNT_BITS:0]     diff;
   logic                              fits;
   logic                              last_step;

   // Quotient stays below 2^MEAN_BITS, so the top of the accumulator is already
   // a valid partial remainder and only MEAN_BITS steps remain.
   assign acc       = prod_ff + kdlt_pkg::ACC_BITS'(sample_ff);
   assign trial     = {rem_ff, quo_ff[kdlt_pkg::MEAN_BITS-1]};
   assign diff      = trial - {1'b0, divisor_ff};
   assign fits      = (trial >= {1'b0, divisor_ff});
   assign last_step = (step_ff == kdlt_pkg::STEP_BITS'(kdlt_pkg::MEAN_BITS - 1));

   always_comb begin
      load_in    = 1'b0;
      run_in     = run_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      prod_in    = prod_ff;
      sample_in  = sample_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (cmd.start) begin
         load_in    = 1'b1;
         prod_in    = kdlt_pkg::ACC_BITS'(cmd.mean)
                    * kdlt_pkg::ACC_BITS'(cmd.count - kdlt_pkg::COUNT_BITS'(1));
         sample_in  = {cmd.interval, {kdlt_pkg::FRAC_BITS{1'b0}}};
         divisor_in = cmd.count;
      end
      if (load_ff) begin
         rem_in  = acc[kdlt_pkg::ACC_BITS-1:kdlt_pkg::MEAN_BITS];
         quo_in  = acc[kdlt_pkg::MEAN_BITS-1:0];
         step_in = '0;
         run_in  = 1'b1;
      end
      if (run_ff) begin
         rem_in  = fits ? diff[kdlt_pkg::COUNT_BITS-1:0] : trial[kdlt_pkg::COUNT_BITS-1:0];
         quo_in  = {quo_ff[kdlt_pkg::MEAN_BITS-2:0], fits};
         step_in = step_ff + kdlt_pkg::STEP_BITS'(1);
         if (last_step) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         load_ff <= load_in;
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      sample_ff  <= sample_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   assign stat     = '{busy: load_ff | run_ff, done: done_ff};
   assign quotient = quo_ff;

endmodule

`default_nettype wire
